[rtl/core/abc_score_note_parser_top_macros.svh]
// Assertion macros for the ABC score note parser top level.
// Expects clk and rst in the scope where a macro is used.
`ifndef ABC_SCORE_NOTE_PARSER_TOP_MACROS_SVH
`define ABC_SCORE_NOTE_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define ASNP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASNP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/asnp_pkg.sv]
// Shared types, constants and decode functions for the ABC score note parser.
// No dependencies.
`default_nettype none

package asnp_pkg;

  localparam int UNIT_BITS = 16;
  localparam int NUM_BITS  = 4;
  localparam int LEN_BITS  = 20;
  localparam int MIDI_BITS = 9;
  localparam int OUT_TIME_BITS = 32;

  localparam logic signed [MIDI_BITS-1:0] BASE_NOTE = 9'sd48;
  localparam logic signed [MIDI_BITS-1:0] SEMIS_PER_OCTAVE = 9'sd12;
  localparam logic [UNIT_BITS-1:0] UNIT_LENGTH_RESET = 16'd300;

  localparam logic [7:0] CH_Z      = 8'h7A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic signed [3:0] SHIFT_MAX = 4'sd7;
  localparam logic signed [3:0] SHIFT_MIN = -4'sd8;

  typedef enum logic [3:0] {
    CC_REST,
    CC_QUOTE,
    CC_SHARP,
    CC_FLAT,
    CC_OCT_UP,
    CC_OCT_DOWN,
    CC_SLASH,
    CC_DIGIT,
    CC_NOTE,
    CC_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_PUSH,
    S_APPLY,
    S_LAST
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // pitch index 0..13 for C..B, c..b; 15 when not a note letter
  function automatic logic [3:0] pitch_index(input logic [7:0] ch);
    logic [3:0] idx;
    begin
      unique case (ch)
        8'h43: idx = 4'd0;
        8'h44: idx = 4'd1;
        8'h45: idx = 4'd2;
        8'h46: idx = 4'd3;
        8'h47: idx = 4'd4;
        8'h41: idx = 4'd5;
        8'h42: idx = 4'd6;
        8'h63: idx = 4'd7;
        8'h64: idx = 4'd8;
        8'h65: idx = 4'd9;
        8'h66: idx = 4'd10;
        8'h67: idx = 4'd11;
        8'h61: idx = 4'd12;
        8'h62: idx = 4'd13;
        default: idx = 4'd15;
      endcase
      return idx;
    end
  endfunction

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t cc;
    begin
      priority if (ch == CH_Z || ch == CH_DOT) cc = CC_REST;
      else if (ch == CH_DQUOTE) cc = CC_QUOTE;
      else if (ch == CH_CARET) cc = CC_SHARP;
      else if (ch == CH_UNDER) cc = CC_FLAT;
      else if (ch == CH_APOS) cc = CC_OCT_UP;
      else if (ch == CH_COMMA) cc = CC_OCT_DOWN;
      else if (ch == CH_SLASH) cc = CC_SLASH;
      else if (ch >= CH_ZERO && ch <= CH_NINE) cc = CC_DIGIT;
      else if (pitch_index(ch) != 4'd15) cc = CC_NOTE;
      else cc = CC_OTHER;
      return cc;
    end
  endfunction

  function automatic logic signed [MIDI_BITS-1:0] degree_semis(input logic [2:0] deg);
    logic signed [MIDI_BITS-1:0] s;
    begin
      unique case (deg)
        3'd0: s = 9'sd0;
        3'd1: s = 9'sd2;
        3'd2: s = 9'sd4;
        3'd3: s = 9'sd5;
        3'd4: s = 9'sd7;
        3'd5: s = 9'sd9;
        3'd6: s = 9'sd11;
        default: s = 9'sd0;
      endcase
      return s;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/asnp_div.sv]
// Length unit: unit_length * numerator, then restoring division, one bit a cycle.
// Depends on asnp_pkg.
`default_nettype none

module asnp_div import asnp_pkg::*; #(
  parameter int DENOM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [UNIT_BITS-1:0]  unit_length,
  input  logic [NUM_BITS-1:0]   numerator,
  input  logic [DENOM_BITS-1:0] denominator,
  output div_status_t           status,
  output logic [LEN_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(LEN_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(LEN_BITS - 1);

  logic                  busy;
  logic                  done;
  logic [CNT_BITS-1:0]   count;
  logic [LEN_BITS-1:0]   dvd;
  logic [DENOM_BITS-1:0] rem;
  logic [DENOM_BITS-1:0] den;
  logic [DENOM_BITS:0]   rem_sh;
  logic [DENOM_BITS:0]   rem_diff;
  logic                  fits;

  assign rem_sh   = {rem, dvd[LEN_BITS-1]};
  assign fits     = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= LEN_BITS'(unit_length) * LEN_BITS'(numerator);
      den <= denominator;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_diff[DENOM_BITS-1:0] : rem_sh[DENOM_BITS-1:0];
      dvd <= {dvd[LEN_BITS-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = dvd;

endmodule

`default_nettype wire

[rtl/core/abc_score_note_parser_top.sv]
// ABC score note parser: one character per request, up to two note results.
// Requests are taken only in S_IDLE; each completion adds the divide steps, the divide
// done and the push, plus any wait while a result is stalled.
// rst (synchronous) clears state, time position and sets unit_length to 300.
// Depends on asnp_pkg, asnp_div and abc_score_note_parser_top_macros.svh.
`default_nettype none

module abc_score_note_parser_top import asnp_pkg::*; #(
  parameter int DENOM_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [UNIT_BITS-1:0]        wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  char_code,
  input  logic                        last_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [OUT_TIME_BITS-1:0]    start_time,
  output logic signed [MIDI_BITS-1:0] midi_note,
  output logic [LEN_BITS-1:0]         note_length,
  output logic                        zero_denominator,
  output logic                        last_of_run
);

  state_t state;
  state_t state_next;

  logic [UNIT_BITS-1:0]  unit_length;
  logic [7:0]            ch;
  logic                  last;
  logic                  phase;
  logic                  in_quoted_text;
  logic [3:0]            pending_pitch_index;
  logic signed [3:0]     octave_shift;
  logic signed [3:0]     semitone_shift;
  logic [NUM_BITS-1:0]   length_numerator;
  logic [DENOM_BITS-1:0] length_denominator;
  logic                  numerator_seen;
  logic                  note_pending;
  logic                  rest_pending;
  logic [TIME_BITS-1:0]  time_position;

  char_class_t           cc;
  logic                  completes;
  logic                  pending;
  logic                  div_start;
  div_status_t           div_status;
  logic [LEN_BITS-1:0]   quotient;
  logic                  zden;
  logic [LEN_BITS-1:0]   len;
  logic                  out_free;
  logic                  push_go;
  logic                  upper;
  logic [2:0]            degree;
  logic signed [MIDI_BITS-1:0] oct9;
  logic signed [MIDI_BITS-1:0] midi;
  logic [TIME_BITS+LEN_BITS-1:0] time_sum;
  logic [TIME_BITS+OUT_TIME_BITS-1:0] time_ext;

  assign cc        = classify(ch);
  assign completes = (cc == CC_REST) || (cc == CC_SHARP) || (cc == CC_FLAT) ||
                     (cc == CC_NOTE);
  assign pending   = note_pending || rest_pending;
  assign zden      = (length_denominator == '0);
  assign len       = zden ? '0 : quotient;
  assign out_free  = !out_valid || !out_stall;
  assign push_go   = !note_pending || out_free;

  assign upper  = pending_pitch_index >= 4'd7;
  assign degree = upper ? 3'(pending_pitch_index - 4'd7) : pending_pitch_index[2:0];
  assign oct9   = MIDI_BITS'(octave_shift) + (upper ? 9'sd1 : 9'sd0);
  assign midi   = degree_semis(degree) + oct9 * SEMIS_PER_OCTAVE +
                  MIDI_BITS'(semitone_shift) + BASE_NOTE;

  assign time_sum = {{LEN_BITS{1'b0}}, time_position} + {{TIME_BITS{1'b0}}, len};
  assign time_ext = {{OUT_TIME_BITS{1'b0}}, time_position};

  asnp_div #(
    .DENOM_BITS(DENOM_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .unit_length(unit_length),
    .numerator  (length_numerator),
    .denominator(length_denominator),
    .status     (div_status),
    .quotient   (quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: state_next = (!in_quoted_text && completes && pending) ? S_DIV : S_APPLY;
      S_DIV:    if (div_status.done) state_next = S_PUSH;
      S_PUSH:   if (push_go) state_next = phase ? S_IDLE : S_APPLY;
      S_APPLY:  state_next = S_LAST;
      S_LAST:   state_next = (last && pending) ? S_DIV : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = 1'b0;
    unique case (state)
      S_DECODE: div_start = !in_quoted_text && completes && pending;
      S_LAST:   div_start = last && pending;
      default:  div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_length <= UNIT_LENGTH_RESET;
    end else if (wr_en) begin
      unit_length <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      ch   <= char_code;
      last <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (state == S_DECODE) begin
      phase <= 1'b0;
    end else if (state == S_LAST) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quoted_text      <= 1'b0;
      pending_pitch_index <= '0;
      octave_shift        <= '0;
      semitone_shift      <= '0;
      length_numerator    <= NUM_BITS'(1);
      length_denominator  <= DENOM_BITS'(1);
      numerator_seen      <= 1'b0;
      note_pending        <= 1'b0;
      rest_pending        <= 1'b0;
      time_position       <= '0;
    end else if (state == S_PUSH && push_go) begin
      time_position       <= time_sum[TIME_BITS-1:0];
      pending_pitch_index <= '0;
      octave_shift        <= '0;
      semitone_shift      <= '0;
      length_numerator    <= NUM_BITS'(1);
      length_denominator  <= DENOM_BITS'(1);
      numerator_seen      <= 1'b0;
      note_pending        <= 1'b0;
      rest_pending        <= 1'b0;
    end else if (state == S_APPLY) begin
      if (in_quoted_text) begin
        if (cc == CC_QUOTE) in_quoted_text <= 1'b0;
      end else begin
        unique case (cc)
          CC_REST:  rest_pending <= 1'b1;
          CC_QUOTE: in_quoted_text <= 1'b1;
          CC_SHARP: if (semitone_shift != SHIFT_MAX) semitone_shift <= semitone_shift + 4'sd1;
          CC_FLAT:  if (semitone_shift != SHIFT_MIN) semitone_shift <= semitone_shift - 4'sd1;
          CC_OCT_UP: if (octave_shift != SHIFT_MAX) octave_shift <= octave_shift + 4'sd1;
          CC_OCT_DOWN: if (octave_shift != SHIFT_MIN) octave_shift <= octave_shift - 4'sd1;
          CC_SLASH: begin
            numerator_seen     <= 1'b1;
            length_denominator <= length_denominator << 1;
          end
          CC_DIGIT: begin
            if (!numerator_seen) begin
              length_numerator <= NUM_BITS'(ch - CH_ZERO);
              numerator_seen   <= 1'b1;
            end else begin
              length_denominator <= DENOM_BITS'(4'(ch - CH_ZERO));
            end
          end
          CC_NOTE: begin
            pending_pitch_index <= pitch_index(ch);
            note_pending        <= 1'b1;
          end
          CC_OTHER: ;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUSH && note_pending && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && note_pending && out_free) begin
      start_time       <= time_ext[OUT_TIME_BITS-1:0];
      midi_note        <= midi;
      note_length      <= len;
      zero_denominator <= zden;
      last_of_run      <= phase || !(last && cc == CC_NOTE);
    end
  end

`include "abc_score_note_parser_top_macros.svh"

  `ASNP_ASSERT_NOW(a_idle_div_quiet, state == S_IDLE, !div_status.busy, "divider busy while idle")
  `ASNP_ASSERT_NOW(a_zden_len, out_valid && zero_denominator, note_length == '0, "zden len")
  `ASNP_ASSERT_NEXT(a_accept_decode, in_valid && !in_stall, state == S_DECODE, "missed decode")

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench for abc_score_note_parser_top: drives score characters and checks note events
// against typed script expectations and a cycle-free predictor kept in step with every accepted request.
// Depends on asnp_pkg and the abc_score_note_parser_top RTL.
`default_nettype none

module testbench import asnp_pkg::*; ();

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 295;
  localparam int NUM_ROWS = 28;
  localparam logic [8*14-1:0] NOTE_LETTERS = "CDEFGABcdefgab";
  localparam int DEGREE_STEPS [7] = '{0, 2, 4, 5, 7, 9, 11};

  typedef struct packed {
    logic [OUT_TIME_BITS-1:0]    start_t;
    logic signed [MIDI_BITS-1:0] midi;
    logic [LEN_BITS-1:0]         len;
    logic                        zden;
    logic                        run_end;
  } note_event_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic [4:0]  reps;
    logic        typed;
    logic [1:0]  n_typed;
    note_event_t first_ev;
    note_event_t second_ev;
  } script_row_t;

  localparam note_event_t NO_EVENT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [UNIT_BITS-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] char_code = '0;
  logic last_char = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_TIME_BITS-1:0] start_time;
  logic signed [MIDI_BITS-1:0] midi_note;
  logic [LEN_BITS-1:0] note_length;
  logic zero_denominator;
  logic last_of_run;

  // parser state as the predictor sees it
  logic [UNIT_BITS-1:0] unit_len = UNIT_LENGTH_RESET;
  logic quoted = 1'b0;
  logic [3:0] pitch_idx = '0;
  logic signed [3:0] oct_shift = '0;
  logic signed [3:0] semi_shift = '0;
  logic [NUM_BITS-1:0] num = 4'd1;
  logic [15:0] den = 16'd1;
  logic num_seen = 1'b0;
  logic note_pend = 1'b0;
  logic rest_pend = 1'b0;
  logic [OUT_TIME_BITS-1:0] tick_pos = '0;

  note_event_t expected_notes[$];
  int errors = 0;
  int fed_count = 0;
  int cycle_count = 0;
  int in_gap_pct = 29;
  int out_stall_pct = 47;

  script_row_t script [NUM_ROWS] = '{
    '{"C", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"D", 1'b1, 5'd1, 1'b1, 2'd2, '{32'd0, 9'sd48, 20'd300, 1'b0, 1'b0},
      '{32'd300, 9'sd50, 20'd300, 1'b0, 1'b1}},
    '{"b", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_APOS, 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_SLASH, 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{8'h00, 1'b1, 5'd1, 1'b1, 2'd1, '{32'd600, 9'sd83, 20'd150, 1'b0, 1'b1}, NO_EVENT},
    '{CH_Z, 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"4", 1'b1, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_COMMA, 1'b0, 5'd9, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_UNDER, 1'b0, 5'd9, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"C", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_SLASH, 1'b0, 5'd16, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"A", 1'b1, 5'd1, 1'b1, 2'd2, '{32'd1950, -9'sd56, 20'd0, 1'b1, 1'b0},
      '{32'd1950, 9'sd57, 20'd300, 1'b0, 1'b1}},
    '{CH_CARET, 1'b0, 5'd8, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_APOS, 1'b0, 5'd8, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"b", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"9", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"7", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_DQUOTE, 1'b1, 5'd1, 1'b1, 2'd1, '{32'd2250, 9'sd162, 20'd385, 1'b0, 1'b1}, NO_EVENT},
    '{"C", 1'b1, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_DQUOTE, 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{CH_DOT, 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"0", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{8'hFF, 1'b1, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"E", 1'b0, 5'd1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{"0", 1'b1, 5'd1, 1'b1, 2'd1, '{32'd2635, 9'sd52, 20'd0, 1'b0, 1'b1}, NO_EVENT},
    '{"G", 1'b0, 5'd1, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{"5", 1'b1, 5'd1, 1'b0, 2'd0, NO_EVENT, NO_EVENT}
  };

  abc_score_note_parser_top uut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .last_char(last_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .start_time(start_time),
    .midi_note(midi_note),
    .note_length(note_length),
    .zero_denominator(zero_denominator),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // closes the pending note or rest; notes become events
  function automatic void close_pending(ref note_event_t evs[$]);
    logic [35:0] product;
    note_event_t ev;
    int idx;
    int midi_val;
    if (!note_pend && !rest_pend) return;
    ev = NO_EVENT;
    ev.zden = (den == 16'd0);
    if (!ev.zden) begin
      product = unit_len * num;
      ev.len = 20'(product / den);
    end
    if (note_pend && evs.size() < 2) begin
      idx = pitch_idx;
      midi_val = DEGREE_STEPS[idx % 7]
                 + (int'(oct_shift) + ((idx >= 7) ? 1 : 0)) * int'(SEMIS_PER_OCTAVE)
                 + int'(semi_shift) + int'(BASE_NOTE);
      ev.start_t = tick_pos;
      ev.midi = midi_val[MIDI_BITS-1:0];
      evs.push_back(ev);
    end
    tick_pos = tick_pos + OUT_TIME_BITS'(ev.len);
    pitch_idx = '0;
    num = 4'd1;
    den = 16'd1;
    num_seen = 1'b0;
    oct_shift = '0;
    semi_shift = '0;
    note_pend = 1'b0;
    rest_pend = 1'b0;
  endfunction

  function automatic void parse_char(input logic [7:0] ch, input logic fin,
                                     ref note_event_t evs[$]);
    evs.delete();
    if (quoted) begin
      if (ch == CH_DQUOTE) quoted = 1'b0;
    end else if (ch == CH_Z || ch == CH_DOT) begin
      close_pending(evs);
      rest_pend = 1'b1;
    end else if (ch == CH_DQUOTE) begin
      quoted = 1'b1;
    end else if (ch == CH_CARET) begin
      close_pending(evs);
      if (semi_shift != SHIFT_MAX) semi_shift = semi_shift + 4'sd1;
    end else if (ch == CH_UNDER) begin
      close_pending(evs);
      if (semi_shift != SHIFT_MIN) semi_shift = semi_shift - 4'sd1;
    end else if (ch == CH_APOS) begin
      if (oct_shift != SHIFT_MAX) oct_shift = oct_shift + 4'sd1;
    end else if (ch == CH_COMMA) begin
      if (oct_shift != SHIFT_MIN) oct_shift = oct_shift - 4'sd1;
    end else if (ch == CH_SLASH) begin
      num_seen = 1'b1;
      den = den << 1;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (!num_seen) begin
        num = 4'(ch - CH_ZERO);
        num_seen = 1'b1;
      end else begin
        den = 16'(ch - CH_ZERO);
      end
    end else begin
      for (int k = 0; k < 14; k++) begin
        if (ch == NOTE_LETTERS[8*(13-k) +: 8]) begin
          close_pending(evs);
          pitch_idx = 4'(k);
          note_pend = 1'b1;
          break;
        end
      end
    end
    if (fin) close_pending(evs);
    if (evs.size() > 0) evs[evs.size()-1].run_end = 1'b1;
  endfunction

  task automatic send_request(input logic [7:0] ch, input logic fin);
    @(negedge clk);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    char_code <= ch;
    last_char <= fin;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed(input logic [7:0] ch, input logic fin);
    note_event_t evs[$];
    send_request(ch, fin);
    parse_char(ch, fin, evs);
    foreach (evs[i]) expected_notes.push_back(evs[i]);
    fed_count++;
  endtask

  function automatic logic rare_last();
    return $urandom_range(29) == 0;
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'(CH_ZERO + $urandom_range(9));
  endfunction

  // mostly well-formed notes and rests, some quoted text, noise and stray marks
  task automatic random_token();
    int pick;
    int n;
    int idx;
    pick = $urandom_range(99);
    if (pick < 60) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 1);
      repeat (n) feed(($urandom_range(1) != 0) ? CH_CARET : CH_UNDER, rare_last());
      if (pick < 50) begin
        idx = $urandom_range(13);
        feed(NOTE_LETTERS[8*(13-idx) +: 8], rare_last());
      end else begin
        feed(($urandom_range(1) != 0) ? CH_Z : CH_DOT, rare_last());
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 2);
      repeat (n) feed(($urandom_range(1) != 0) ? CH_APOS : CH_COMMA, rare_last());
      if ($urandom_range(1) != 0) feed(any_digit(), rare_last());
      n = ($urandom_range(11) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 2);
      repeat (n) feed(CH_SLASH, rare_last());
      if ($urandom_range(2) == 0) feed(any_digit(), rare_last());
    end else if (pick < 66) begin
      feed(CH_DQUOTE, rare_last());
      repeat ($urandom_range(0, 6)) feed(8'($urandom_range(255)), rare_last());
      feed(CH_DQUOTE, rare_last());
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) feed(8'($urandom_range(255)), rare_last());
    end else begin
      case ($urandom_range(5))
        0: feed(CH_CARET, rare_last());
        1: feed(CH_UNDER, rare_last());
        2: feed(CH_APOS, rare_last());
        3: feed(CH_COMMA, rare_last());
        4: feed(CH_SLASH, rare_last());
        default: feed(any_digit(), rare_last());
      endcase
    end
  endtask

  // only while idle: drain results, let a resultless request finish, then write
  task automatic write_unit_length(input logic [UNIT_BITS-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    wr_en <= 1'b1;
    wr_data <= value;
    @(negedge clk);
    wr_en <= 1'b0;
    unit_len = value;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < out_stall_pct);

  always @(posedge clk) begin : check_notes
    note_event_t got;
    note_event_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{start_time, midi_note, note_length, zero_denominator, last_of_run};
      if (expected_notes.size() == 0) begin
        errors++;
        $display("%0t: expected no note event, got %0d %0d %0d %b %b",
                 $time, got.start_t, $signed(got.midi), got.len, got.zden, got.run_end);
      end else begin
        want = expected_notes.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: note event expected %0d %0d %0d %b %b, got %0d %0d %0d %b %b",
                   $time, want.start_t, $signed(want.midi), want.len, want.zden,
                   want.run_end, got.start_t, $signed(got.midi), got.len, got.zden,
                   got.run_end);
        end
      end
    end
  end

  initial begin : timeout
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("abc_score_note_parser_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    note_event_t step_evs[$];
    logic [UNIT_BITS-1:0] unit_plan [PHASES];
    unit_plan = '{16'hFFFF, 16'd1, 16'd0, 16'd7, 16'd0, 16'hFFFF};
    unit_plan[2] = 16'($urandom_range(2, 65534));
    unit_plan[4] = 16'($urandom_range(2, 65534));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      repeat (script[r].reps) begin
        send_request(script[r].ch, script[r].fin);
        parse_char(script[r].ch, script[r].fin, step_evs);
        if (script[r].typed) begin
          if (script[r].n_typed > 0) expected_notes.push_back(script[r].first_ev);
          if (script[r].n_typed > 1) expected_notes.push_back(script[r].second_ev);
        end else begin
          foreach (step_evs[i]) expected_notes.push_back(step_evs[i]);
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_unit_length(unit_plan[ph]);
      case (ph / 2)
        0: begin
          in_gap_pct = 29;
          out_stall_pct = 47;
        end
        1: begin
          in_gap_pct = 47;
          out_stall_pct = 29;
        end
        default: begin
          in_gap_pct = 0;
          out_stall_pct = 0;
        end
      endcase
      fed_count = 0;
      while (fed_count < ITEMS_PER_PHASE) random_token();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("abc_score_note_parser_top: match");
    else
      $display("abc_score_note_parser_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
